### hdl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants for the difference-encoded minimum stack.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int DIFF_W      = VAL_W + 1;
    localparam int OCNT_W      = 7;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_POP_WAIT
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] top_value;
        logic signed [VAL_W-1:0] min_value;
        logic [OCNT_W-1:0]       entry_count;
        t_status                 status;
    } t_result;

endpackage

`default_nettype wire

### hdl/msd_in_if.sv
// ----------------------------------------------------------------------------
// msd_in_if
// Request channel: push or pop beat with its value.
// ----------------------------------------------------------------------------
`default_nettype none

interface msd_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
    modport mon    (input valid, input func, input value, input ready);
endinterface

`default_nettype wire

### hdl/msd_out_if.sv
// ----------------------------------------------------------------------------
// msd_out_if
// Result channel: top, minimum, count and status per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface msd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic [6:0]         entry_count;
    logic [1:0]         status;

    modport source (output valid, output top_value, output min_value,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input top_value, input min_value,
                    input entry_count, input status, output ready);
    modport mon    (input valid, input top_value, input min_value,
                    input entry_count, input status, input ready);
endinterface

`default_nettype wire

### hdl/min_stack_difference_encoded_top.sv
// ----------------------------------------------------------------------------
// min_stack_difference_encoded_top
// Minimum stack holding 33-bit differences against a running minimum.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : request beats (func 0 push value, 1 pop), valid/ready.
//   o_out : one result beat per request: top, minimum, count, status.
//   Differences live in a single-port-style RAM (one read, one write per
//   cycle, registered read). The top difference is also held in a register,
//   so a push or a trivial pop writes its result straight into the output
//   register; a pop that leaves entries behind reads the new top from RAM
//   and answers from the S_POP_WAIT state. One request is in flight at a
//   time: pushes and trivial pops flow at 1 beat/cycle while the receiver
//   keeps up, and no request is taken in S_POP_WAIT.
//   The result sits in an output register; the next request is taken while
//   that register drains. If the receiver stalls, i_in.ready drops until the
//   held result is taken.
//   Reset clears the count, the minimum and the output valid; the RAM is
//   not cleared, entries are read only after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module min_stack_difference_encoded_top (
    input  wire       i_clk,
    input  wire       i_rst_n,
    msd_in_if.sink    i_in,
    msd_out_if.source o_out
);
    import msd_pkg::*;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [VAL_W-1:0]  r_min, n_min;
    logic signed [DIFF_W-1:0] r_top_diff, n_top_diff;
    logic signed [DIFF_W-1:0] r_rd_data;
    logic signed [DIFF_W-1:0] mem [STACK_DEPTH];

    logic                     r_out_valid;
    t_result                  r_out, res;
    logic                     load_out;

    logic                     in_ready;
    logic                     accept;
    logic                     mem_we, mem_re;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic signed [DIFF_W-1:0] wr_data;
    logic signed [DIFF_W-1:0] push_diff;
    logic [CNT_W-1:0]         cnt_inc, cnt_dec, cnt_dec2;
    logic [VAL_W+1:0]         pop_min_wide;

    function automatic logic signed [VAL_W-1:0] top_of(
        input logic signed [DIFF_W-1:0] d,
        input logic signed [VAL_W-1:0]  mn
    );
        logic [VAL_W-1:0] sum;
        sum = d[VAL_W-1:0] + mn;
        if (!d[DIFF_W-1] && (d != '0)) begin
            return sum;
        end else begin
            return mn;
        end
    endfunction

    assign accept   = i_in.valid && in_ready;
    assign cnt_inc  = r_count + CNT_W'(1);
    assign cnt_dec  = r_count - CNT_W'(1);
    assign cnt_dec2 = r_count - CNT_W'(2);
    assign push_diff = $signed({i_in.value[VAL_W-1], i_in.value})
                     - $signed({r_min[VAL_W-1], r_min});
    assign pop_min_wide = {r_min[VAL_W-1], r_min[VAL_W-1], r_min}
                        - {r_top_diff[DIFF_W-1], r_top_diff};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_in.func == FUNC_POP) && (r_count > CNT_W'(1))) begin
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        unique case (r_state)
            S_IDLE:     in_ready = !r_out_valid || o_out.ready;
            S_POP_WAIT: in_ready = 1'b0;
            default:    in_ready = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        n_count    = r_count;
        n_min      = r_min;
        n_top_diff = r_top_diff;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        wr_addr    = r_count[ADDR_W-1:0];
        wr_data    = push_diff;
        rd_addr    = cnt_dec2[ADDR_W-1:0];
        load_out   = 1'b0;
        res        = '{top_value: '0, min_value: '0,
                       entry_count: OCNT_W'(r_count), status: ST_OK};

        if (r_state == S_POP_WAIT) begin
            n_top_diff      = r_rd_data;
            load_out        = 1'b1;
            res.top_value   = top_of(r_rd_data, r_min);
            res.min_value   = r_min;
        end else if (accept) begin
            load_out = 1'b1;
            if (i_in.func == FUNC_PUSH) begin
                if (r_count == CNT_W'(STACK_DEPTH)) begin
                    res.top_value = top_of(r_top_diff, r_min);
                    res.min_value = r_min;
                    res.status    = ST_FULL;
                end else if (r_count == '0) begin
                    mem_we          = 1'b1;
                    wr_data         = '0;
                    n_top_diff      = '0;
                    n_min           = i_in.value;
                    n_count         = cnt_inc;
                    res.top_value   = i_in.value;
                    res.min_value   = i_in.value;
                    res.entry_count = OCNT_W'(cnt_inc);
                end else begin
                    mem_we          = 1'b1;
                    n_top_diff      = push_diff;
                    n_min           = (i_in.value < r_min) ? i_in.value : r_min;
                    n_count         = cnt_inc;
                    res.top_value   = i_in.value;
                    res.min_value   = n_min;
                    res.entry_count = OCNT_W'(cnt_inc);
                end
            end else begin
                if (r_count == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    n_count         = cnt_dec;
                    n_min           = r_top_diff[DIFF_W-1] ? pop_min_wide[VAL_W-1:0] : r_min;
                    res.entry_count = OCNT_W'(cnt_dec);
                    if (r_count != CNT_W'(1)) begin
                        mem_re   = 1'b1;
                        load_out = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_min       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_min   <= n_min;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_diff <= n_top_diff;
        if (load_out) begin
            r_out <= res;
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.top_value   = r_out.top_value;
    assign o_out.min_value   = r_out.min_value;
    assign o_out.entry_count = r_out.entry_count;
    assign o_out.status      = r_out.status;

endmodule

`default_nettype wire

### hdl/msd_checker.sv
// ----------------------------------------------------------------------------
// msd_checker
// Port-level checks for the minimum stack, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_out_valid,
    input wire                         i_out_ready,
    input wire [msd_pkg::VAL_W-1:0]    i_out_top_value,
    input wire [msd_pkg::VAL_W-1:0]    i_out_min_value,
    input wire [msd_pkg::OCNT_W-1:0]   i_out_entry_count,
    input wire [1:0]                   i_out_status
);
    import msd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_top_value)
            && $stable(i_out_min_value) && $stable(i_out_entry_count)
            && $stable(i_out_status))
        else $error("result beat changed while stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_entry_count <= OCNT_W'(STACK_DEPTH)))
        else $error("entry count beyond stack depth");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == ST_FULL)
            |-> (i_out_entry_count == OCNT_W'(STACK_DEPTH)))
        else $error("full flag with stack not full");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_entry_count == '0)
            |-> (i_out_top_value == '0) && (i_out_min_value == '0))
        else $error("empty stack reports non-zero top or minimum");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == ST_EMPTY) |-> (i_out_entry_count == '0))
        else $error("empty flag with entries held");

endmodule

bind min_stack_difference_encoded_top msd_checker u_msd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_top_value   (o_out.top_value),
    .i_out_min_value   (o_out.min_value),
    .i_out_entry_count (o_out.entry_count),
    .i_out_status      (o_out.status)
);

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the difference-encoded minimum stack.
// A queue of push/pop requests (a short directed opening, then random
// fill/drain/mixed episodes) feeds a clocked driver. A clocked monitor
// predicts each accepted request and checks every result beat in order.
// Both sides idle in random bursts, and the bench also holds the result
// side off for a long stretch and drains the block fully at set points.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import msd_pkg::*;

    localparam int N_ITEMS    = 1850;
    localparam int CALM_TAIL  = 300;
    localparam int HOLD_AT    = 500;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        bit                 pause;
        logic               func;
        logic signed [31:0] value;
    } req_t;

    logic i_clk;
    logic i_rst_n;

    msd_in_if  in_if ();
    msd_out_if out_if ();

    min_stack_difference_encoded_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    req_t    pending_reqs[$];
    t_result expected_results[$];
    int      pending_results = 0;
    int      beats_in = 0;
    int      n_total = 0;
    int      n_errors = 0;
    int      n_results = 0;
    int      src_gap = 0;
    int      sink_gap = 0;
    int      hold_left = 0;
    bit      hold_done = 0;

    // stack shadow
    logic signed [DIFF_W-1:0] diffs[STACK_DEPTH];
    logic signed [VAL_W-1:0]  run_min = '0;
    int                       depth_used = 0;

    int n_push = 0, n_pop = 0, n_full = 0, n_empty = 0, n_restore = 0;
    int peak_depth = 0, stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.func   = FUNC_PUSH;
        in_if.value  = '0;
        out_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic bit idle_allowed();
        return (beats_in < n_total - CALM_TAIL) && ((beats_in / 256) % 4 != 3);
    endfunction

    function automatic t_result apply_op(logic func, logic signed [31:0] value);
        t_result             r;
        logic signed [32:0]  d;
        longint              v;
        longint              m;
        v = value;
        m = run_min;
        r.status = ST_OK;
        if (func == FUNC_PUSH) begin
            n_push++;
            if (depth_used >= STACK_DEPTH) begin
                r.status = ST_FULL;
                n_full++;
            end else if (depth_used == 0) begin
                diffs[0]   = '0;
                run_min    = value;
                depth_used = 1;
            end else begin
                diffs[depth_used] = 33'(v - m);
                if (value < run_min) run_min = value;
                depth_used++;
            end
        end else begin
            n_pop++;
            if (depth_used == 0) begin
                r.status = ST_EMPTY;
                n_empty++;
            end else begin
                depth_used--;
                d = diffs[depth_used];
                if (d < 0) begin
                    run_min = 32'(m - longint'(d));
                    n_restore++;
                end
            end
        end
        r.top_value = '0;
        r.min_value = '0;
        if (depth_used > 0) begin
            d = diffs[depth_used-1];
            r.min_value = run_min;
            r.top_value = (d > 0) ? 32'(longint'(d) + longint'(run_min)) : run_min;
        end
        r.entry_count = 7'(depth_used);
        if (depth_used > peak_depth) peak_depth = depth_used;
        return r;
    endfunction

    task automatic add_req(logic func, logic signed [31:0] value);
        req_t r;
        r.pause = 1'b0;
        r.func  = func;
        r.value = value;
        pending_reqs.push_back(r);
        n_total++;
    endtask

    task automatic add_pause();
        req_t r;
        r.pause = 1'b1;
        r.func  = FUNC_PUSH;
        r.value = '0;
        pending_reqs.push_back(r);
    endtask

    function automatic logic signed [31:0] pick_value(logic signed [31:0] last);
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'($signed($urandom_range(0, 20)) - 10);
            3:       return last + 32'($signed($urandom_range(0, 6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    // request list
    initial begin : build_reqs
        int                 len;
        int                 push_pct;
        logic signed [31:0] last;
        last = '0;
        add_req(FUNC_POP, 32'sh1234_5678);
        add_req(FUNC_PUSH, 32'sh7fff_ffff);
        add_req(FUNC_PUSH, 32'sh8000_0000);
        add_req(FUNC_PUSH, 32'sh0000_0000);
        add_req(FUNC_PUSH, 32'sh7fff_ffff);
        repeat (4) add_req(FUNC_POP, 32'shffff_ffff);
        add_req(FUNC_POP, '0);
        add_req(FUNC_PUSH, -32'sd5);
        add_req(FUNC_PUSH, -32'sd5);
        add_req(FUNC_PUSH, 32'sd3);
        add_req(FUNC_PUSH, -32'sd10);
        repeat (4) add_req(FUNC_POP, '0);
        add_req(FUNC_POP, 32'sh7fff_ffff);
        add_pause();
        while (n_total < N_ITEMS) begin
            case ($urandom_range(0, 5))
                0: begin len = $urandom_range(66, 80); push_pct = 100; end
                1: begin len = $urandom_range(66, 80); push_pct = 0;   end
                2: begin len = $urandom_range(20, 140); push_pct = 85; end
                3: begin len = $urandom_range(20, 140); push_pct = 15; end
                default: begin len = $urandom_range(10, 80); push_pct = 50; end
            endcase
            if (len > N_ITEMS - n_total) len = N_ITEMS - n_total;
            repeat (len) begin
                if ($urandom_range(0, 99) < push_pct) begin
                    last = pick_value(last);
                    add_req(FUNC_PUSH, last);
                end else begin
                    add_req(FUNC_POP, $urandom);
                end
            end
            if (n_total > 900 && n_total - len <= 900) add_pause();
        end
    end

    always @(posedge i_clk) begin : drive
        bit   load;
        req_t r;
        load = 1'b0;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (pending_reqs.size() > 0) begin
                if (pending_reqs[0].pause) begin
                    if (!in_if.valid && pending_results == 0) void'(pending_reqs.pop_front());
                end else if (idle_allowed() && $urandom_range(0, 15) == 0) begin
                    src_gap = $urandom_range(0, 18);
                end else begin
                    load = 1'b1;
                end
            end
            if (load) begin
                r = pending_reqs.pop_front();
                in_if.valid <= 1'b1;
                in_if.func  <= r.func;
                in_if.value <= r.value;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // long result-side hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && beats_in >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            out_if.ready <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 11) == 0) begin
            sink_gap = $urandom_range(0, 18);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (in_if.valid && !in_if.ready) stall_cycles++;
            if (in_if.valid && in_if.ready) begin
                expected_results.push_back(apply_op(in_if.func, in_if.value));
                beats_in <= beats_in + 1;
            end
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result beat %0d with nothing expected", n_results));
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.top_value !== want.top_value)
                        report_error($sformatf("beat %0d top_value got %h want %h",
                                     n_results, out_if.top_value, want.top_value));
                    if (out_if.min_value !== want.min_value)
                        report_error($sformatf("beat %0d min_value got %h want %h",
                                     n_results, out_if.min_value, want.min_value));
                    if (out_if.entry_count !== want.entry_count)
                        report_error($sformatf("beat %0d entry_count got %0d want %0d",
                                     n_results, out_if.entry_count, want.entry_count));
                    if (out_if.status !== want.status)
                        report_error($sformatf("beat %0d status got %0d want %0d",
                                     n_results, out_if.status, want.status));
                end
            end
            pending_results <= expected_results.size();
        end
    end

    initial begin : finish_run
        wait (i_rst_n === 1'b1);
        do @(negedge i_clk); while (pending_reqs.size() != 0 || in_if.valid);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        $display("Run: %0d requests (%0d push, %0d pop), %0d results, peak depth %0d.",
                 beats_in, n_push, n_pop, n_results, peak_depth);
        $display("Seen: %0d full drops, %0d empty pops, %0d min restores, %0d stalled cycles.",
                 n_full, n_empty, n_restore, stall_cycles);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
hdl/msd_pkg.sv
hdl/msd_in_if.sv
hdl/msd_out_if.sv
hdl/min_stack_difference_encoded_top.sv
hdl/msd_checker.sv
dv/tb_top.sv
